@@ rtl/core/mcpid_pkg.sv @@
// Shared types, constants and register codes of the multi-channel PID speed controller.
package mcpid_pkg;

  localparam int CHANNELS   = 3;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NUM_DRIVES = 3;

  localparam logic [10:0] FRAME_BASE = 11'h200;

  localparam int SCALE_NUM   = 10000;
  localparam int SCALE_DEN   = 13000;
  localparam int SCALE_SHIFT = 24;
  localparam longint SCALE_MULT =
    (longint'(SCALE_NUM) * (longint'(1) << SCALE_SHIFT) + longint'(SCALE_DEN) - 1)
    / longint'(SCALE_DEN);

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = MUL_P_W;
  localparam int FRAC_W  = 20;
  localparam int WHOLE_W = SUM_W - FRAC_W;
  localparam int MAG_W   = 16;

  localparam logic signed [WHOLE_W-1:0] WHOLE_HI =
    WHOLE_W'((32768 * SCALE_DEN - 1) / SCALE_NUM);
  localparam logic signed [WHOLE_W-1:0] WHOLE_LO =
    -WHOLE_W'((32769 * SCALE_DEN - 1) / SCALE_NUM);

  localparam logic signed [15:0] PROP_GAIN_RST  = 16'sd4096;
  localparam logic signed [15:0] INTEG_GAIN_RST = 16'sd0;
  localparam logic signed [15:0] DERIV_GAIN_RST = 16'sd123;
  localparam logic [15:0]        STEP_TIME_RST  = 16'd1311;
  localparam logic [11:0]        STEP_RATE_RST  = 12'd50;

  typedef enum logic [2:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_STEP_TIME  = 3'd3,
    CFG_STEP_RATE  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic               func;
    logic [10:0]        frame_id;
    logic signed [15:0] feedback_speed;
    logic signed [15:0] setpoint_a;
    logic signed [15:0] setpoint_b;
    logic signed [15:0] setpoint_c;
    logic signed [15:0] direct_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] drive_a;
    logic signed [15:0] drive_b;
    logic signed [15:0] drive_c;
    logic signed [15:0] drive_d;
  } out_item_t;

endpackage

@@ rtl/core/mcpid_mul.sv @@
// Shared signed multiplier with registered product.
module mcpid_mul
  import mcpid_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output logic signed [MUL_P_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

@@ rtl/core/multi_channel_pid_speed_controller.sv @@
// Top level: three PID speed loops sharing one gain set, run on one multiplier.
//
// Input channel (in_valid/in_ready/in_data): a feedback transaction (func 0)
// stores the measured speed of channel frame_id - 0x201 when the id is in
// 0x201..0x200+CHANNELS; in_ready stays high. A tick transaction (func 1)
// runs the PID update of every channel and yields one result.
// Result channel (out_valid/out_ready/out_data): drive_a..c and the
// pass-through drive_d, held in an output register until taken.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready; write only while no tick is in flight.
// Sequencing: a tick steps through the channels in turn, then the output
// step. Each channel takes ten sequencer steps, six of them through the
// one shared 33x25 multiplier. in_ready drops for the whole tick, so no
// new transaction is taken until its result is in the output register.
// If the receiver stalls, the finished result waits in the output register,
// feedback is still accepted, and the next tick completes its math then
// waits in its last step until the register is free.
// Reset (rst_n low, synchronous) restores the gains, clears speeds, errors
// and integrals, and empties the output register.
module multi_channel_pid_speed_controller
  import mcpid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
    S_WHOLE, S_SCALE, S_DRIVE, S_OUT
  } state_t;

  state_t              state_r;
  logic [CH_W-1:0]     ch_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic signed [15:0]  prop_gain_r;
  logic signed [15:0]  integ_gain_r;
  logic signed [15:0]  deriv_gain_r;
  logic [15:0]         step_time_r;
  logic [11:0]         step_rate_r;

  logic signed [15:0]  meas_r  [CHANNELS];
  logic signed [16:0]  prev_r  [CHANNELS];
  logic signed [31:0]  integ_r [CHANNELS];

  logic signed [15:0]  sp_a_r, sp_b_r, sp_c_r, direct_r;
  logic signed [16:0]  err_r;
  logic signed [17:0]  diff_r;
  logic signed [31:0]  acc_r;
  logic signed [30:0]  der_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [MAG_W-1:0]    mag_r;
  logic                neg_r;
  logic signed [15:0]  drive_r [NUM_DRIVES];

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [MUL_P_W-1:0] prod_r;

  logic                in_acc, out_acc, cfg_acc, load_out, last_ch;
  logic                fb_hit;
  logic [CH_W-1:0]     fb_idx;
  logic signed [15:0]  sp_sel, meas_sel;
  logic signed [16:0]  err_w;
  logic signed [17:0]  diff_w;
  logic signed [33:0]  tp_w, tadj_w, acc_w;
  logic signed [25:0]  term_w;
  logic signed [31:0]  acc_sat_w;
  logic signed [SUM_W-1:0]   sadj_w;
  logic signed [WHOLE_W-1:0] whole_w, wclamp_w, wabs_w;
  logic [MAG_W-1:0]    q_w;
  logic signed [15:0]  drv_w;
  logic [1:0]          drv_idx;

  mcpid_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_acc   = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign load_out  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign last_ch   = (32'(ch_r) == CHANNELS - 1);

  assign fb_hit = (in_data.frame_id > FRAME_BASE) &&
                  (32'(in_data.frame_id) <= 32'(FRAME_BASE) + CHANNELS);
  assign fb_idx = CH_W'(in_data.frame_id - FRAME_BASE - 11'd1);

  always_comb begin
    if (32'(ch_r) == 0) begin
      sp_sel = sp_a_r;
    end else if (32'(ch_r) == 1) begin
      sp_sel = sp_b_r;
    end else if (32'(ch_r) == 2) begin
      sp_sel = sp_c_r;
    end else begin
      sp_sel = '0;
    end
  end

  assign meas_sel = meas_r[ch_r];
  assign err_w    = {sp_sel[15], sp_sel} - {meas_sel[15], meas_sel};
  assign diff_w   = {err_w[16], err_w} - {prev_r[ch_r][16], prev_r[ch_r]};

  assign tp_w      = prod_r[33:0];
  assign tadj_w    = tp_w + {26'd0, {8{tp_w[33]}}};
  assign term_w    = tadj_w[33:8];
  assign acc_w     = {{2{integ_r[ch_r][31]}}, integ_r[ch_r]} + {{8{term_w[25]}}, term_w};

  always_comb begin
    if (acc_w[33:31] == 3'b000 || acc_w[33:31] == 3'b111) begin
      acc_sat_w = acc_w[31:0];
    end else if (acc_w[33]) begin
      acc_sat_w = {1'b1, 31'd0};
    end else begin
      acc_sat_w = {1'b0, {31{1'b1}}};
    end
  end

  assign sadj_w  = sum_r + {{(SUM_W - FRAC_W){1'b0}}, {FRAC_W{sum_r[SUM_W-1]}}};
  assign whole_w = sadj_w[SUM_W-1:FRAC_W];

  always_comb begin
    if (whole_w > WHOLE_HI) begin
      wclamp_w = WHOLE_HI;
    end else if (whole_w < WHOLE_LO) begin
      wclamp_w = WHOLE_LO;
    end else begin
      wclamp_w = whole_w;
    end
    wabs_w = wclamp_w[WHOLE_W-1] ? -wclamp_w : wclamp_w;
  end

  assign q_w     = prod_r[SCALE_SHIFT + MAG_W - 1:SCALE_SHIFT];
  assign drv_w   = neg_r ? $signed(16'd0 - q_w) : $signed(q_w);
  assign drv_idx = 2'(ch_r);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_M1: begin
        op_a = MUL_A_W'(err_r);
        op_b = MUL_B_W'($signed({1'b0, step_time_r}));
      end
      S_M2: begin
        op_a = MUL_A_W'(diff_r);
        op_b = MUL_B_W'($signed({1'b0, step_rate_r}));
      end
      S_M3: begin
        op_a = MUL_A_W'(err_r);
        op_b = MUL_B_W'(prop_gain_r);
      end
      S_M4: begin
        op_a = MUL_A_W'(acc_r);
        op_b = MUL_B_W'(integ_gain_r);
      end
      S_M5: begin
        op_a = MUL_A_W'(der_r);
        op_b = MUL_B_W'(deriv_gain_r);
      end
      S_SCALE: begin
        op_a = MUL_A_W'($signed({1'b0, mag_r}));
        op_b = MUL_B_W'(SCALE_MULT);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ch_r         <= '0;
      out_valid_r  <= 1'b0;
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      step_time_r  <= STEP_TIME_RST;
      step_rate_r  <= STEP_RATE_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        meas_r[i]  <= '0;
        prev_r[i]  <= '0;
        integ_r[i] <= '0;
      end
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_PROP_GAIN:  prop_gain_r  <= cfg_data;
          CFG_INTEG_GAIN: integ_gain_r <= cfg_data;
          CFG_DERIV_GAIN: deriv_gain_r <= cfg_data;
          CFG_STEP_TIME:  step_time_r  <= cfg_data;
          CFG_STEP_RATE:  step_rate_r  <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.func) begin
              ch_r    <= '0;
              state_r <= S_LOAD;
            end else if (fb_hit) begin
              meas_r[fb_idx] <= in_data.feedback_speed;
            end
          end
        end
        S_LOAD: begin
          prev_r[ch_r] <= err_w;
          state_r      <= S_M1;
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          integ_r[ch_r] <= acc_sat_w;
          state_r       <= S_M3;
        end
        S_M3:    state_r <= S_M4;
        S_M4:    state_r <= S_M5;
        S_M5:    state_r <= S_M6;
        S_M6:    state_r <= S_WHOLE;
        S_WHOLE: state_r <= S_SCALE;
        S_SCALE: state_r <= S_DRIVE;
        S_DRIVE: begin
          if (last_ch) begin
            state_r <= S_OUT;
          end else begin
            ch_r    <= ch_r + CH_W'(1);
            state_r <= S_LOAD;
          end
        end
        S_OUT: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.func) begin
      sp_a_r   <= in_data.setpoint_a;
      sp_b_r   <= in_data.setpoint_b;
      sp_c_r   <= in_data.setpoint_c;
      direct_r <= in_data.direct_value;
      for (int i = 0; i < NUM_DRIVES; i++) begin
        drive_r[i] <= '0;
      end
    end
    if (state_r == S_LOAD) begin
      err_r  <= err_w;
      diff_r <= diff_w;
    end
    if (state_r == S_M2) begin
      acc_r <= acc_sat_w;
    end
    if (state_r == S_M3) begin
      der_r <= prod_r[30:0];
    end
    if (state_r == S_M4) begin
      sum_r <= prod_r <<< 8;
    end
    if (state_r == S_M5) begin
      sum_r <= sum_r + prod_r;
    end
    if (state_r == S_M6) begin
      sum_r <= sum_r + (prod_r <<< 8);
    end
    if (state_r == S_WHOLE) begin
      mag_r <= wabs_w[MAG_W-1:0];
      neg_r <= wclamp_w[WHOLE_W-1];
    end
    if (state_r == S_DRIVE && 32'(ch_r) < NUM_DRIVES) begin
      drive_r[drv_idx] <= drv_w;
    end
    if (load_out) begin
      out_data_r.drive_a <= drive_r[0];
      out_data_r.drive_b <= drive_r[1];
      out_data_r.drive_c <= drive_r[2];
      out_data_r.drive_d <= direct_r;
    end
  end

`ifndef SYNTH
  a_tick_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func |=> !in_ready)
    else $error("input still ready after tick transaction");

  a_feedback_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.func |=> in_ready)
    else $error("feedback transaction started the sequencer");

  a_result_from_sequencer: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT))
    else $error("result appeared outside the output step");

  a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ch_r) < CHANNELS)
    else $error("channel counter out of range");

  a_last_channel_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRIVE && last_ch |=> state_r == S_OUT)
    else $error("sequencer did not finish after last channel");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the multi-channel PID speed controller.
`timescale 1ns / 1ps

module testbench;
  import mcpid_pkg::*;

  localparam logic FUNC_FEEDBACK = 1'b0;
  localparam logic FUNC_TICK     = 1'b1;

  localparam logic [10:0] ID_FIRST = FRAME_BASE + 11'd1;
  localparam logic [10:0] ID_LAST  = FRAME_BASE + 11'(CHANNELS);

  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam longint INT32_TOP = 64'sd2147483647;
  localparam longint INT32_BOT = -64'sd2147483648;

  localparam int SETTLE_CYCLES = 10 * CHANNELS + 10;
  localparam int ITEM_W        = $bits(in_item_t);

  typedef enum logic [1:0] {ROW_FEEDBACK, ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] sel;
    logic [15:0] val;
    logic [15:0] sp_a;
    logic [15:0] sp_b;
    logic [15:0] sp_c;
    logic [15:0] direct;
    bit          literal;
    out_item_t   want;
  } dir_row_t;

  typedef struct {
    int          send_idle;
    int          recv_stall;
    int          items;
    int          bias;
    bit          rand_cfg;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [15:0] tstep;
    logic [15:0] rate;
  } phase_t;

  localparam int DIR_ROWS = 36;
  localparam int PHASES   = 9;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_TICK,     16'h000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      64'h0000_0000_0000_0000},
    '{ROW_FEEDBACK, 16'(FRAME_BASE), 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      1'b0, 64'h0},
    '{ROW_FEEDBACK, 16'(ID_LAST + 11'd1), 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      1'b0, 64'h0},
    '{ROW_FEEDBACK, 16'h7FF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 64'h0},
    '{ROW_FEEDBACK, 16'h000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 64'h0},
    '{ROW_TICK,     16'(ID_FIRST), 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 1'b1,
      64'h0000_0000_0000_7FFF},
    '{ROW_TICK,     16'h000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b1,
      64'h0000_0000_0000_8000},
    '{ROW_FEEDBACK, 16'(ID_FIRST), 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      1'b0, 64'h0},
    '{ROW_FEEDBACK, 16'(ID_FIRST + 11'd1), 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      1'b0, 64'h0},
    '{ROW_FEEDBACK, 16'(ID_LAST), 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      1'b0, 64'h0},
    '{ROW_TICK,     16'h000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h1234, 1'b0, 64'h0},
    '{ROW_TICK,     16'h000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h5555, 1'b0, 64'h0},
    '{ROW_TICK,     16'h000, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hAAAA, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_PROP_GAIN),  16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_INTEG_GAIN), 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_DERIV_GAIN), 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_STEP_TIME),  16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_STEP_RATE),  16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_TICK,     16'h000, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, 64'h0},
    '{ROW_TICK,     16'h000, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_PROP_GAIN),  16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_INTEG_GAIN), 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_DERIV_GAIN), 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_STEP_TIME),  16'h0001, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_STEP_RATE),  16'h0001, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_TICK,     16'h000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 64'h0},
    '{ROW_TICK,     16'h000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_STEP_TIME),  16'h0000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_STEP_RATE),  16'h0000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_PROP_GAIN),  16'h0000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_TICK,     16'h000, 16'h0000, 16'h1000, 16'hF000, 16'h0040, 16'h0000, 1'b0, 64'h0},
    '{ROW_TICK,     16'h000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_SPARE_LO),   16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_SPARE_HI),   16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_CFG,      16'(CFG_PROP_GAIN),  16'h1000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0},
    '{ROW_TICK,     16'h000, 16'h0000, 16'h0064, 16'hFF9C, 16'h0000, 16'h0000, 1'b0, 64'h0}
  };

  phase_t phases [PHASES] = '{
    '{0,  0,  190, 0,  1'b0, PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, STEP_TIME_RST,
      16'(STEP_RATE_RST)},
    '{55, 0,  190, 0,  1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{0,  55, 190, 0,  1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0FFF},
    '{26, 26, 190, 0,  1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h0001, 16'h0001},
    '{0,  0,  240, 1,  1'b0, 16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001},
    '{26, 26, 240, -1, 1'b0, 16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001},
    '{55, 0,  190, 0,  1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{0,  55, 190, 0,  1'b0, 16'h0400, 16'h00C8, 16'h0032, 16'h0000, 16'h0000},
    '{26, 26, 190, 0,  1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}
  };

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  logic signed [15:0] kp     = PROP_GAIN_RST;
  logic signed [15:0] ki     = INTEG_GAIN_RST;
  logic signed [15:0] kd     = DERIV_GAIN_RST;
  logic [15:0]        step_t = STEP_TIME_RST;
  logic [11:0]        step_r = STEP_RATE_RST;

  logic signed [15:0] meas_speed [CHANNELS] = '{default: '0};
  logic signed [16:0] last_err   [CHANNELS] = '{default: '0};
  logic signed [31:0] err_integ  [CHANNELS] = '{default: '0};

  out_item_t pending_drives [$];
  out_item_t oldest_drive;
  int        fails          = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  multi_channel_pid_speed_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [15:0] channel_drive(int ch, logic signed [15:0] sp);
    longint s, m, err, acc, der, sum, whole, scaled;
    longint tp, rt, gp, gi, gd, pe, ia;
    s = sp;
    m = meas_speed[ch];
    tp = step_t;
    rt = step_r;
    gp = kp;
    gi = ki;
    gd = kd;
    pe = last_err[ch];
    ia = err_integ[ch];
    err = s - m;
    acc = ia + (err * tp) / 256;
    if (acc > INT32_TOP) acc = INT32_TOP;
    else if (acc < INT32_BOT) acc = INT32_BOT;
    err_integ[ch] = acc[31:0];
    der = (err - pe) * rt;
    last_err[ch] = err[16:0];
    sum = gp * err * 256 + gi * acc + gd * der * 256;
    whole = sum / 1048576;
    scaled = whole * SCALE_NUM / SCALE_DEN;
    if (scaled > 32767) scaled = 32767;
    else if (scaled < -32768) scaled = -32768;
    return scaled[15:0];
  endfunction

  function automatic out_item_t tick_drives(in_item_t it);
    logic signed [15:0] sp  [NUM_DRIVES];
    logic signed [15:0] drv [NUM_DRIVES];
    logic signed [15:0] d;
    out_item_t          r;
    int                 ch;
    sp = '{it.setpoint_a, it.setpoint_b, it.setpoint_c};
    drv = '{default: '0};
    for (ch = 0; ch < CHANNELS; ch++) begin
      d = channel_drive(ch, (ch < NUM_DRIVES) ? sp[ch] : 16'sd0);
      if (ch < NUM_DRIVES) drv[ch] = d;
    end
    r.drive_a = drv[0];
    r.drive_b = drv[1];
    r.drive_c = drv[2];
    r.drive_d = it.direct_value;
    return r;
  endfunction

  function automatic void note_feedback(in_item_t it);
    if (it.frame_id >= ID_FIRST && it.frame_id <= ID_LAST)
      meas_speed[CH_W'(it.frame_id - ID_FIRST)] = it.feedback_speed;
  endfunction

  function automatic void mirror_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      CFG_PROP_GAIN:  kp = data;
      CFG_INTEG_GAIN: ki = data;
      CFG_DERIV_GAIN: kd = data;
      CFG_STEP_TIME:  step_t = data;
      CFG_STEP_RATE:  step_r = data[11:0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_speed();
    int roll;
    int near;
    roll = $urandom_range(0, 99);
    near = $urandom_range(0, 4000);
    if (roll < 20) begin
      case ($urandom_range(0, 4))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        3: return 16'sh0001;
        default: return 16'shFFFF;
      endcase
    end
    if (roll < 60) return 16'(near - 2000);
    return 16'($urandom);
  endfunction

  function automatic in_item_t rand_item(int bias);
    in_item_t it;
    it = ITEM_W'({$urandom, $urandom, $urandom});
    if (bias != 0) begin
      if ($urandom_range(0, 99) < 80) begin
        it.func = FUNC_TICK;
        it.setpoint_a = (bias > 0) ? 16'sh7FFF : 16'sh8000;
        it.setpoint_b = it.setpoint_a;
        it.setpoint_c = it.setpoint_a;
      end else begin
        it.func = FUNC_FEEDBACK;
        it.frame_id = ID_FIRST + 11'($urandom_range(0, CHANNELS - 1));
        it.feedback_speed = (bias > 0) ? 16'sh8000 : 16'sh7FFF;
      end
      return it;
    end
    if ($urandom_range(0, 99) < 55) begin
      it.func = FUNC_TICK;
      it.setpoint_a = rand_speed();
      it.setpoint_b = rand_speed();
      it.setpoint_c = rand_speed();
    end else begin
      it.func = FUNC_FEEDBACK;
      if ($urandom_range(0, 99) < 85)
        it.frame_id = ID_FIRST + 11'($urandom_range(0, CHANNELS - 1));
      it.feedback_speed = rand_speed();
    end
    return it;
  endfunction

  task automatic push_item(in_item_t it, bit literal, out_item_t want);
    out_item_t got;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.func == FUNC_TICK) begin
      got = tick_drives(it);
      pending_drives.push_back(literal ? want : got);
    end else begin
      note_feedback(it);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    mirror_reg(idx, data);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_drives.size() != 0);
  endtask

  task automatic settle_block();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
    if (got !== want) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        fails++;
        $error("result transaction with no tick pending");
      end else begin
        oldest_drive = pending_drives.pop_front();
        check_field("drive_a", oldest_drive.drive_a, out_data.drive_a);
        check_field("drive_b", oldest_drive.drive_b, out_data.drive_b);
        check_field("drive_c", oldest_drive.drive_c, out_data.drive_c);
        check_field("drive_d", oldest_drive.drive_d, out_data.drive_d);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_item_t it;
    bit       prev_cfg;
    int       kept;
    int       p;
    int       r;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 26;
    recv_stall_pct = 26;
    prev_cfg = 1'b0;
    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        if (!prev_cfg) settle_block();
        write_reg(dir_rows[r].sel[2:0], dir_rows[r].val);
      end else begin
        if (prev_cfg) cfg_valid <= 1'b0;
        it.func           = (dir_rows[r].kind == ROW_TICK) ? FUNC_TICK : FUNC_FEEDBACK;
        it.frame_id       = dir_rows[r].sel[10:0];
        it.feedback_speed = dir_rows[r].val;
        it.setpoint_a     = dir_rows[r].sp_a;
        it.setpoint_b     = dir_rows[r].sp_b;
        it.setpoint_c     = dir_rows[r].sp_c;
        it.direct_value   = dir_rows[r].direct;
        push_item(it, dir_rows[r].literal, dir_rows[r].want);
      end
      prev_cfg = (dir_rows[r].kind == ROW_CFG);
    end

    for (p = 0; p < PHASES; p++) begin
      settle_block();
      if (phases[p].rand_cfg) begin
        write_reg(CFG_PROP_GAIN,  16'($urandom));
        write_reg(CFG_INTEG_GAIN, 16'($urandom));
        write_reg(CFG_DERIV_GAIN, 16'($urandom));
        write_reg(CFG_STEP_TIME,  16'($urandom));
        write_reg(CFG_STEP_RATE,  16'($urandom));
        write_reg(CFG_SPARE_LO + 3'($urandom_range(0, 2)), 16'($urandom));
      end else begin
        write_reg(CFG_PROP_GAIN,  phases[p].kp);
        write_reg(CFG_INTEG_GAIN, phases[p].ki);
        write_reg(CFG_DERIV_GAIN, phases[p].kd);
        write_reg(CFG_STEP_TIME,  phases[p].tstep);
        write_reg(CFG_STEP_RATE,  phases[p].rate);
      end
      cfg_valid <= 1'b0;
      send_idle_pct  = phases[p].send_idle;
      recv_stall_pct = phases[p].recv_stall;
      kept = 0;
      while (kept < phases[p].items) begin
        it = rand_item(phases[p].bias);
        push_item(it, 1'b0, '0);
        if (it.func == FUNC_TICK || (it.frame_id >= ID_FIRST && it.frame_id <= ID_LAST))
          kept++;
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
